>>> src/sha256_stream_hasher_macros.svh
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/sha_pkg.sv
package sha_pkg;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LENGTH_OFFSET = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> src/sha256_stream_hasher.sv
// channel | ports                                             | direction
// input   | in_valid in_stall in_byte_value in_carries_byte  | in
//         | in_end_of_message                                 |
// result  | out_valid out_stall out_digest_word               | out
//         | out_word_index out_last_word                      |
// a data byte is written into the block memory; a full block goes through a
// load state, 64 rounds (one per cycle, the first 16 schedule words read from
// the memory one per cycle) and a fold state
// an end item writes padding one byte per cycle to the end of one or two
// blocks, each then compressed, then 8 result transactions; in_stall is high
// whenever the block is busy; synchronous active-low reset clears control state
module sha256_stream_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte_value,
  input  logic                 in_carries_byte,
  input  logic                 in_end_of_message,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha_pkg::word_t       out_digest_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // block memory: 16 words, byte writes by read-modify-write-free lane enables
  word_t      blk_mem [16];
  logic [5:0] wr_addr;
  logic [7:0] wr_data;
  logic       wr_en;
  logic [3:0] rd_addr;
  word_t      rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
    end
    rd_word_r <= blk_mem[rd_addr];
  end

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] count_r, count_nxt;
  logic        fin_r, fin_nxt;
  logic        mark_r, mark_nxt;
  logic        len_r, len_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];
  logic [2:0]  oidx_r, oidx_nxt;
  logic        ovld_r, ovld_nxt;

  logic [63:0] bits;
  word_t       wt, s0, s1, t1, t2, wn;
  logic        ld_word, rnd_go;
  logic [5:0]  ridx;

  assign bits = {count_r, 3'd0};
  assign ridx = cnt_r[5:0];

  always_comb begin
    s0 = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    wt = (cnt_r < 7'd16) ? rd_word_r : wn;
    t1 = v_r[7] + (ror32(v_r[4], 6) ^ ror32(v_r[4], 11) ^ ror32(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[ridx] + wt;
    t2 = (ror32(v_r[0], 2) ^ ror32(v_r[0], 13) ^ ror32(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    oidx_nxt  = oidx_r;
    ovld_nxt  = ovld_r;
    wr_en     = 1'b0;
    wr_addr   = fill_r;
    wr_data   = in_byte_value;
    rd_addr   = 4'd0;
    ld_word   = 1'b0;
    rnd_go    = 1'b0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_carries_byte) begin
            wr_en     = 1'b1;
            fill_nxt  = fill_r + 6'd1;
            count_nxt = count_r + 61'd1;
          end
          fin_nxt = in_end_of_message;
          if (in_carries_byte && fill_r == 6'd63) begin
            state_nxt = S_LOAD;
            cnt_nxt   = 7'd0;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
            cnt_nxt   = 7'd0;
          end
        end
      end
      S_PAD: begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (!mark_r) begin
          wr_data  = PAD_MARK;
          mark_nxt = 1'b1;
          len_nxt  = len_r || (fill_r < LENGTH_OFFSET);
        end else if (len_r && fill_r >= LENGTH_OFFSET) begin
          wr_data = bits[8'(63 - 8 * int'(fill_r[2:0])) -: 8];
        end else begin
          wr_data = 8'd0;
        end
        if (fill_r == 6'd63) begin
          state_nxt = S_LOAD;
          cnt_nxt   = 7'd0;
        end
      end
      S_LOAD: begin
        rd_addr   = 4'd0;
        state_nxt = S_RND;
        cnt_nxt   = 7'd0;
      end
      S_RND: begin
        rd_addr = cnt_r[3:0] + 4'd1;
        rnd_go  = 1'b1;
        ld_word = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (!len_r) begin
          state_nxt = S_PAD;
          len_nxt   = 1'b1;
        end else begin
          state_nxt = S_OUT;
          oidx_nxt  = 3'd0;
          ovld_nxt  = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            ovld_nxt  = 1'b0;
            state_nxt = S_IDLE;
            fin_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            len_nxt   = 1'b0;
            count_nxt = '0;
            fill_nxt  = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      count_r <= '0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      len_r   <= 1'b0;
      cnt_r   <= '0;
      oidx_r  <= '0;
      ovld_r  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= INIT_HASH[i];
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      oidx_r  <= oidx_nxt;
      ovld_r  <= ovld_nxt;
      if (state_r == S_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (state_r == S_OUT && !out_stall && oidx_r == 3'd7) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= INIT_HASH[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (rnd_go) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (ld_word) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= wt;
    end
  end

  assign out_valid       = ovld_r;
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

`include "sha256_stream_hasher_macros.svh"

  `SHA_ASSERT_IMPL(a_out_only_in_out, clk, rst_n, out_valid, state_r == S_OUT)
  `SHA_ASSERT_IMPL(a_busy_stalls, clk, rst_n, state_r != S_IDLE, in_stall)
  `SHA_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && !out_stall && out_last_word,
                   state_r == S_IDLE && fill_r == 6'd0)

endmodule
